@@ rtl/fwrv_pkg.sv @@
// fwrv_pkg: operation, status and result-select codes, plus the command and
// status structs shared by the controller and the datapath of the queue.
// No dependencies.
`default_nettype none

package fwrv_pkg;

  localparam int WORD_W  = 64;
  localparam int KIND_W  = 2;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 5;
  localparam int RSEL_W  = 2;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // result word selection
  localparam logic [RSEL_W-1:0] RES_ZERO  = 2'd0;
  localparam logic [RSEL_W-1:0] RES_ONES  = 2'd1;
  localparam logic [RSEL_W-1:0] RES_WORD  = 2'd2;
  localparam logic [RSEL_W-1:0] RES_RDATA = 2'd3;

  typedef struct packed {
    logic              take;      // latch the incoming transaction
    logic              push_wr;   // append operand at the tail
    logic              pop_rd;    // read the head entry
    logic              pop_fin;   // drop the head entry
    logic              srch;      // one search step
    logic              shft;      // one compaction step
    logic              rm_fin;    // drop the last entry after compaction
    logic              set_res;   // capture result word and status
    logic [RSEL_W-1:0] res_sel;
    logic [ST_W-1:0]   status;
    logic              load_out;  // move result to the output register
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              hit;
    logic              miss;
    logic              shft_done;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/fwrv_if.sv @@
// fwrv_if: valid/ready channel interfaces for operations in and results out.
// Depends on fwrv_pkg for the field widths.
`default_nettype none

interface fwrv_in_if;
  import fwrv_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [WORD_W-1:0]   word;

  modport source (output valid, output kind, output word, input ready);
  modport sink   (input valid, input kind, input word, output ready);
endinterface

interface fwrv_out_if;
  import fwrv_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   result_word;
  logic [ST_W-1:0]     status;
  logic                is_empty;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, output result_word, output status, output is_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input result_word, input status, input is_empty,
                  input entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/fwrv_dp.sv @@
// fwrv_dp: queue datapath - circular entry memory, head and count, search and
// compaction pointers, result and output registers.
// Depends on fwrv_pkg.
`default_nettype none

module fwrv_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [fwrv_pkg::KIND_W-1:0] in_kind_i,
  input  wire logic [fwrv_pkg::WORD_W-1:0] in_word_i,
  input  wire fwrv_pkg::cmd_t            cmd_i,
  output fwrv_pkg::sts_t                 sts_o,
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output logic [fwrv_pkg::WORD_W-1:0]    out_result_word_o,
  output logic [fwrv_pkg::ST_W-1:0]      out_status_o,
  output logic                           out_is_empty_o,
  output logic [fwrv_pkg::CNT_W-1:0]     out_entry_count_o
);
  import fwrv_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem_q [DEPTH];

  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     hole_q, hole_d;
  logic              chk_q, chk_d;
  logic              out_valid_q, out_valid_d;

  logic [KIND_W-1:0] kind_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] res_q;
  logic [ST_W-1:0]   st_q;
  logic [WORD_W-1:0] out_word_q;
  logic [ST_W-1:0]   out_st_q;
  logic              out_empty_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic              rd_en, wr_en;
  logic [CW-1:0]     rd_pos, wr_pos;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              eq, hit, miss, full, empty;
  logic [CW+CNT_W-1:0] cnt_ext;

  // physical slot of a position counted from the head
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(pos);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign eq    = (rdata_q == word_q);
  assign hit   = chk_q & eq;
  assign miss  = chk_q & ~eq & (pos_q == count_q);

  assign sts_o.kind      = kind_q;
  assign sts_o.full      = full;
  assign sts_o.empty     = empty;
  assign sts_o.hit       = hit;
  assign sts_o.miss      = miss;
  assign sts_o.shft_done = ~chk_q & (pos_q == count_q);
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign rd_addr = slot_of(head_q, rd_pos);
  assign wr_addr = slot_of(head_q, wr_pos);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    hole_d  = hole_q;
    chk_d   = 1'b0;
    rd_en   = 1'b0;
    rd_pos  = pos_q;
    wr_en   = 1'b0;
    wr_pos  = hole_q;
    wr_data = rdata_q;

    if (cmd_i.take) begin
      pos_d = '0;
    end
    if (cmd_i.push_wr) begin
      wr_en   = 1'b1;
      wr_pos  = count_q;
      wr_data = word_q;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop_rd) begin
      rd_en  = 1'b1;
      rd_pos = '0;
    end
    if (cmd_i.pop_fin) begin
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.srch) begin
      if (hit) begin
        // matched entry becomes the hole, its successor is read next
        hole_d = pos_q - 1'b1;
      end else if (pos_q < count_q) begin
        rd_en = 1'b1;
        pos_d = pos_q + 1'b1;
        chk_d = 1'b1;
      end
    end
    if (cmd_i.shft) begin
      if (chk_q) begin
        wr_en  = 1'b1;
        hole_d = hole_q + 1'b1;
      end
      if (pos_q < count_q) begin
        rd_en = 1'b1;
        pos_d = pos_q + 1'b1;
        chk_d = 1'b1;
      end
    end
    if (cmd_i.rm_fin) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      hole_q      <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      hole_q      <= hole_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign cnt_ext = {{CNT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= in_kind_i;
      word_q <= in_word_i;
    end
    if (cmd_i.set_res) begin
      st_q <= cmd_i.status;
      case (cmd_i.res_sel)
        RES_ONES:  res_q <= '1;
        RES_WORD:  res_q <= word_q;
        RES_RDATA: res_q <= rdata_q;
        default:   res_q <= '0;
      endcase
    end
    if (cmd_i.load_out) begin
      out_word_q  <= res_q;
      out_st_q    <= st_q;
      out_empty_q <= empty;
      out_cnt_q   <= cnt_ext[CNT_W-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_result_word_o = out_word_q;
  assign out_status_o      = out_st_q;
  assign out_is_empty_o    = out_empty_q;
  assign out_entry_count_o = out_cnt_q;

endmodule

`default_nettype wire

@@ rtl/fwrv_ctrl.sv @@
// fwrv_ctrl: sequencer for push, pop and remove-by-value operations.
// Depends on fwrv_pkg; drives the datapath through cmd_t, watches sts_t.
`default_nettype none

module fwrv_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fwrv_pkg::sts_t sts_i,
  output fwrv_pkg::cmd_t      cmd_o
);
  import fwrv_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POPR = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_SHFT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.set_res = 1'b1;
        cmd_o.res_sel = RES_ZERO;
        cmd_o.status  = ST_OK;
        state_d       = S_DONE;
        case (sts_i.kind)
          KIND_PUSH: begin
            if (sts_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.push_wr = 1'b1;
            end
          end
          KIND_POP: begin
            if (sts_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.set_res = 1'b0;
              cmd_o.pop_rd  = 1'b1;
              state_d       = S_POPR;
            end
          end
          KIND_REMOVE: begin
            if (sts_i.empty) begin
              cmd_o.res_sel = RES_ONES;
              cmd_o.status  = ST_NOT_FOUND;
            end else begin
              cmd_o.set_res = 1'b0;
              state_d       = S_SRCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_POPR: begin
        cmd_o.pop_fin = 1'b1;
        cmd_o.set_res = 1'b1;
        cmd_o.res_sel = RES_RDATA;
        cmd_o.status  = ST_OK;
        state_d       = S_DONE;
      end
      S_SRCH: begin
        cmd_o.srch = 1'b1;
        if (sts_i.hit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_WORD;
          cmd_o.status  = ST_OK;
          state_d       = S_SHFT;
        end else if (sts_i.miss) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_ONES;
          cmd_o.status  = ST_NOT_FOUND;
          state_d       = S_DONE;
        end
      end
      S_SHFT: begin
        // close the gap left by the removed entry, one slot per cycle
        if (sts_i.shft_done) begin
          cmd_o.rm_fin = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.shft = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fifo_with_remove_by_value.sv @@
// Ordered queue of up to DEPTH 64-bit words: push, pop and remove-by-value.
// Search and compaction run one entry per cycle over the entry memory. One transaction
// in flight; the next is taken the cycle after the result is loaded into the output
// register, which waits while a held result is not yet taken. Reset empties the queue
// at once, no clearing pass.
// Depends on fwrv_pkg, fwrv_if, fwrv_ctrl, fwrv_dp.
`default_nettype none

module fifo_with_remove_by_value #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fwrv_in_if.sink    in_i,
  fwrv_out_if.source out_o
);
  import fwrv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fwrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fwrv_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_kind_i         (in_i.kind),
    .in_word_i         (in_i.word),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_result_word_o (out_o.result_word),
    .out_status_o      (out_o.status),
    .out_is_empty_o    (out_o.is_empty),
    .out_entry_count_o (out_o.entry_count)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking bench for fifo_with_remove_by_value, directed table then random traffic.
// Scores each result against a queue predictor held in the bench, or against the table's values for typed rows.
// Depends on fwrv_pkg, fwrv_if and the rtl top level.
`timescale 1ns / 100ps

module tb;
  import fwrv_pkg::*;

  localparam int DEPTH = 16;
  localparam int N_RANDOM = 1600;
  localparam int N_CALM = 200;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [ST_W-1:0]   status;
    logic              empty;
    logic [CNT_W-1:0]  count;
  } result_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    bit                typed;
    result_t           want;
  } op_row_t;

  logic clk_i;
  logic rst_ni;

  fwrv_in_if  in_if ();
  fwrv_out_if out_if ();

  fifo_with_remove_by_value #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [WORD_W-1:0] held_words[$];
  result_t           pending_results[$];
  op_row_t           directed_ops[$];

  int  n_errors = 0;
  int  n_results = 0;
  int  n_sent = 0;
  int  n_full = 0;
  int  n_hits = 0;
  int  n_misses = 0;
  int  n_emptied = 0;
  int  peak_fill = 0;
  bit  gaps_on = 1'b1;
  bit  calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("fifo_with_remove_by_value regression: fail");
    $finish;
  end

  // queue behaviour: order kept, first match from the head taken out on remove
  function automatic result_t apply_queue_op(input logic [KIND_W-1:0] kind,
                                             input logic [WORD_W-1:0] word);
    result_t r;
    int      pos;
    r = '0;
    pos = -1;
    case (kind)
      KIND_PUSH: begin
        if (held_words.size() >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          held_words.push_back(word);
        end
      end
      KIND_POP: begin
        if (held_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = held_words.pop_front();
          if (held_words.size() == 0) n_emptied++;
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < held_words.size(); i++) begin
          if (pos < 0 && held_words[i] == word) pos = i;
        end
        if (pos < 0) begin
          r.word   = ALL_ONES;
          r.status = ST_NOT_FOUND;
          n_misses++;
        end else begin
          r.word = word;
          held_words.delete(pos);
          n_hits++;
          if (held_words.size() == 0) n_emptied++;
        end
      end
      default: ;
    endcase
    if (held_words.size() > peak_fill) peak_fill = held_words.size();
    r.empty = (held_words.size() == 0);
    r.count = CNT_W'(held_words.size());
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] exp_v);
    n_errors++;
    $display("%0t: %s mismatch, got %h expected %h", $time, field, got, exp_v);
  endtask

  task automatic add_row(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                         input bit typed, input logic [WORD_W-1:0] rw,
                         input logic [ST_W-1:0] st, input logic emp, input int cnt);
    op_row_t row;
    row.kind  = kind;
    row.word  = word;
    row.typed = typed;
    row.want  = '{word: rw, status: st, empty: emp, count: cnt[CNT_W-1:0]};
    directed_ops.push_back(row);
  endtask

  // one transaction on the operation channel, expectation logged on acceptance
  task automatic drive_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                          input bit typed, input result_t want);
    result_t predicted;
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.word  <= word;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
    predicted = apply_queue_op(kind, word);
    pending_results.push_back(typed ? want : predicted);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_word(input bit favour_held);
    logic [WORD_W-1:0] w;
    int                sel;
    sel = $urandom_range(0, 15);
    w = {$urandom, $urandom};
    if (favour_held && held_words.size() != 0 && sel < 12) begin
      w = held_words[$urandom_range(0, held_words.size() - 1)];
    end else if (sel < 4 && held_words.size() != 0) begin
      w = held_words[$urandom_range(0, held_words.size() - 1)];
    end else if (sel < 7) begin
      // small values pile up duplicates, so first-match ordering gets exercised
      w = WORD_W'($urandom_range(0, 5));
    end else if (sel == 7) begin
      w = ALL_ONES;
    end
    return w;
  endfunction

  // result side back-pressure
  initial begin
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (calm) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, word", out_if.result_word, '0);
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (out_if.result_word !== want.word)
          report_mismatch("result_word", out_if.result_word, want.word);
        if (out_if.status !== want.status)
          report_mismatch("status", WORD_W'(out_if.status), WORD_W'(want.status));
        if (out_if.is_empty !== want.empty)
          report_mismatch("is_empty", WORD_W'(out_if.is_empty), WORD_W'(want.empty));
        if (out_if.entry_count !== want.count)
          report_mismatch("entry_count", WORD_W'(out_if.entry_count),
                          WORD_W'(want.count));
      end
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] fill_word;
    int                roll;
    bit                filling;

    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.kind  <= KIND_PUSH;
    in_if.word  <= '0;

    // empty-queue cases, unused kind, all-ones word found, then fill to the brim
    add_row(KIND_POP,     64'h0,  1'b1, 64'h0,    ST_EMPTY,     1'b1, 0);
    add_row(KIND_REMOVE,  64'h5,  1'b1, ALL_ONES, ST_NOT_FOUND, 1'b1, 0);
    add_row(KIND_UNUSED,  ALL_ONES, 1'b1, 64'h0,  ST_OK,        1'b1, 0);
    add_row(KIND_PUSH,    64'h0,  1'b1, 64'h0,    ST_OK,        1'b0, 1);
    add_row(KIND_PUSH,    ALL_ONES, 1'b1, 64'h0,  ST_OK,        1'b0, 2);
    add_row(KIND_REMOVE,  ALL_ONES, 1'b1, ALL_ONES, ST_OK,      1'b0, 1);
    for (int i = 0; i < DEPTH - 1; i++) begin
      // slot ten repeats slot three so the remove below must take the earlier copy
      fill_word = 64'h0123_4567_89ab_cdef * ((i == 10) ? 4 : i + 1);
      add_row(KIND_PUSH, fill_word, 1'b0, '0, ST_OK, 1'b0, 0);
    end
    add_row(KIND_PUSH,    64'hfedc_ba98_7654_3210, 1'b1, 64'h0, ST_FULL, 1'b0, DEPTH);
    add_row(KIND_REMOVE,  64'h0,  1'b1, 64'h0,    ST_OK,        1'b0, DEPTH - 1);
    add_row(KIND_REMOVE,  64'h0123_4567_89ab_cdef * 4, 1'b0, '0, ST_OK, 1'b0, 0);
    add_row(KIND_REMOVE,  64'h0123_4567_89ab_cdef * 15, 1'b0, '0, ST_OK, 1'b0, 0);
    add_row(KIND_POP,     64'h8000_0000_0000_0000, 1'b0, '0, ST_OK, 1'b0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i]) begin
      drive_op(directed_ops[i].kind, directed_ops[i].word, directed_ops[i].typed,
               directed_ops[i].want);
    end

    // alternate fill-heavy and drain-heavy stretches so full and empty are both reached
    for (int i = 0; i < N_RANDOM; i++) begin
      filling = ((i / 48) % 2 == 0);
      gaps_on = ((i / 100) % 3 != 2);
      calm    = (i >= N_RANDOM - N_CALM);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        kind = KIND_UNUSED;
        word = {$urandom, $urandom};
      end else if (roll < (filling ? 62 : 30)) begin
        kind = KIND_PUSH;
        word = pick_word(1'b0);
      end else if (roll < (filling ? 72 : 58)) begin
        kind = KIND_POP;
        word = {$urandom, $urandom};
      end else begin
        kind = KIND_REMOVE;
        word = pick_word(1'b1);
      end
      drive_op(kind, word, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 10) @(posedge clk_i);

    $display("%0d operations sent, %0d results checked, peak fill %0d of %0d",
             n_sent, n_results, peak_fill, DEPTH);
    $display("refused pushes %0d, remove hits %0d, remove misses %0d, drained to empty %0d",
             n_full, n_hits, n_misses, n_emptied);
    if (n_errors == 0) begin
      $display("fifo_with_remove_by_value regression: pass");
    end else begin
      $display("fifo_with_remove_by_value regression: fail");
    end
    $finish;
  end

endmodule

@@ fifo_with_remove_by_value.f @@
rtl/fwrv_pkg.sv
rtl/fwrv_if.sv
rtl/fwrv_dp.sv
rtl/fwrv_ctrl.sv
rtl/fifo_with_remove_by_value.sv
tb/sv/tb.sv
